// ----- sv/fpba_pkg.sv -----
// shared types and constants of the fit policy block allocator
package fpba_pkg;

  localparam int unsigned INDEX_W    = 4;
  localparam int unsigned SIZE_IN_W  = 16;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned POLICY_W   = 2;
  localparam int unsigned COUNT_W    = 5;

  // action codes of an input request
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_FIT_POLICY  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_COUNT = 2'd1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

  typedef enum logic [POLICY_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_policy_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } alloc_state_e;

  // search token handed from cell to cell
  typedef struct packed {
    logic active;
    logic found;
  } scan_tok_t;

  // write command broadcast to all cells
  typedef struct packed {
    logic en;
    logic sub;
  } wr_cmd_t;

endpackage

// ----- sv/fpba_if.sv -----
// handshake channels of the fit policy block allocator

interface fpba_in_if;
  import fpba_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [INDEX_W-1:0]   block_index;
  logic [SIZE_IN_W-1:0] size_value;
  modport source (output valid, action, block_index, size_value, input ready);
  modport sink   (input valid, action, block_index, size_value, output ready);
endinterface

interface fpba_out_if;
  import fpba_pkg::*;
  logic               valid;
  logic               ready;
  logic               granted;
  logic [INDEX_W-1:0] chosen_block;
  modport source (output valid, granted, chosen_block, input ready);
  modport sink   (input valid, granted, chosen_block, output ready);
endinterface

interface fpba_cfg_if;
  import fpba_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ----- sv/fit_policy_block_allocator.sv -----
// top level of the fit policy block allocator
//
// usage: requests enter on req_i; a load (action 0) sets the free size of
// block block_index, an allocation (action 1) asks for size_value and yields
// one result on rsp_o with granted and chosen_block. loads give no result
// and block indexes at or above NUM_BLOCKS are dropped.
// configuration (fit policy, block count) is written on cfg_i; the user must
// write it only while idle (not enforced by the block); cfg_i is always ready.
// sequence: a load is written into its cell straight from idle. an allocation
// sends a search token down the row of NUM_BLOCKS cells, one cell per cycle,
// then writes the chosen cell back and passes its result to the output
// register; the input stays not ready from acceptance until that hand-off.
// reset: control state clears, fit policy becomes first fit and block count
// 16; block sizes hold no value until loaded.
// stall: the result sits in an output register; loads keep being accepted
// while it waits, and a finished search waits in its done state until the
// output register is free.
module fit_policy_block_allocator
  import fpba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = 16,
  parameter int unsigned SIZE_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fpba_in_if.sink     req_i,
  fpba_out_if.source  rsp_o,
  fpba_cfg_if.sink    cfg_i
);

  localparam int unsigned IDX_W     = $clog2(NUM_BLOCKS);
  localparam int unsigned SEL_CMP_W = ((IDX_W > INDEX_W) ? IDX_W : INDEX_W) + 1;
  localparam int unsigned CNT_CMP_W = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 1;

  // configuration registers
  logic [POLICY_W-1:0]   policy_q;
  logic [COUNT_W-1:0]    block_count_q;

  // control
  alloc_state_e          state_q, state_d;
  logic                  start_q, start_d;
  logic                  rsp_valid_q, rsp_valid_d;
  logic                  req_fire;
  logic                  out_load;

  // payload registers
  logic [SIZE_WIDTH-1:0] req_size_q;
  logic                  res_granted_q;
  logic [IDX_W-1:0]      res_idx_q;
  logic                  granted_q;
  logic [INDEX_W-1:0]    chosen_q;

  // broadcast write bus
  wr_cmd_t               wr_cmd;
  logic [IDX_W-1:0]      wr_sel;
  logic [SIZE_WIDTH-1:0] wr_data;
  logic [SEL_CMP_W-1:0]  load_sel_wide;
  logic                  load_hit;

  // chain between cells
  scan_tok_t             tok       [NUM_BLOCKS+1];
  logic [IDX_W-1:0]      pick_idx  [NUM_BLOCKS+1];
  logic [SIZE_WIDTH-1:0] pick_size [NUM_BLOCKS+1];
  logic [NUM_BLOCKS-1:0] in_range;

  assign req_fire      = req_i.valid && req_i.ready;
  assign load_sel_wide = SEL_CMP_W'(req_i.block_index);
  assign load_hit      = load_sel_wide < SEL_CMP_W'(NUM_BLOCKS);

  // configuration writes, always accepted
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q      <= FIT_FIRST;
      block_count_q <= COUNT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.addr)
        CFG_FIT_POLICY:  policy_q      <= cfg_i.data[POLICY_W-1:0];
        CFG_BLOCK_COUNT: block_count_q <= cfg_i.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // head of the chain: a fresh token enters cell 0 in the cycle after an allocation is accepted
  assign tok[0]       = '{active: start_q, found: 1'b0};
  assign pick_idx[0]  = '0;
  assign pick_size[0] = '0;

  for (genvar j = 0; j < NUM_BLOCKS; j++) begin : g_cell
    // cells at or beyond block_count take no part in the search
    assign in_range[j] = CNT_CMP_W'(j) < CNT_CMP_W'(block_count_q);

    fpba_cell #(
      .INDEX      (j),
      .IDX_W      (IDX_W),
      .SIZE_WIDTH (SIZE_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_range_i  (in_range[j]),
      .policy_i    (policy_q),
      .wr_cmd_i    (wr_cmd),
      .wr_sel_i    (wr_sel),
      .data_i      (wr_data),
      .tok_i       (tok[j]),
      .pick_idx_i  (pick_idx[j]),
      .pick_size_i (pick_size[j]),
      .tok_o       (tok[j+1]),
      .pick_idx_o  (pick_idx[j+1]),
      .pick_size_o (pick_size[j+1])
    );
  end

  // sequencer: idle accepts requests, scan waits for the token, done hands off
  always_comb begin
    state_d     = state_q;
    start_d     = 1'b0;
    req_i.ready = 1'b0;
    out_load    = 1'b0;
    wr_cmd      = '0;
    wr_sel      = IDX_W'(load_sel_wide);
    wr_data     = SIZE_WIDTH'(req_i.size_value);
    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_fire) begin
          if (req_i.action == ACT_REQUEST) begin
            start_d = 1'b1;
            state_d = ST_SCAN;
          end else begin
            wr_cmd.en = load_hit;
          end
        end
      end
      ST_SCAN: begin
        // during the search the bus carries the requested size
        wr_data = req_size_q;
        if (tok[NUM_BLOCKS].active) begin
          // take the request out of the chosen block
          wr_cmd.en  = tok[NUM_BLOCKS].found;
          wr_cmd.sub = 1'b1;
          wr_sel     = pick_idx[NUM_BLOCKS];
          state_d    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign rsp_valid_d = out_load | (rsp_valid_q & ~rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire && (req_i.action == ACT_REQUEST)) begin
      req_size_q <= SIZE_WIDTH'(req_i.size_value);
    end
    if ((state_q == ST_SCAN) && tok[NUM_BLOCKS].active) begin
      res_granted_q <= tok[NUM_BLOCKS].found;
      res_idx_q     <= tok[NUM_BLOCKS].found ? pick_idx[NUM_BLOCKS] : '0;
    end
    if (out_load) begin
      granted_q <= res_granted_q;
      chosen_q  <= INDEX_W'(res_idx_q);
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.granted      = granted_q;
  assign rsp_o.chosen_block = chosen_q;

endmodule

// ----- sv/fpba_cell.sv -----
// one block cell: holds a remaining size and updates the passing search token
module fpba_cell
  import fpba_pkg::*;
#(
  parameter int unsigned INDEX      = 0,
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned SIZE_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_range_i,
  input  logic [POLICY_W-1:0]   policy_i,
  input  wr_cmd_t               wr_cmd_i,
  input  logic [IDX_W-1:0]      wr_sel_i,
  input  logic [SIZE_WIDTH-1:0] data_i,
  input  scan_tok_t             tok_i,
  input  logic [IDX_W-1:0]      pick_idx_i,
  input  logic [SIZE_WIDTH-1:0] pick_size_i,
  output scan_tok_t             tok_o,
  output logic [IDX_W-1:0]      pick_idx_o,
  output logic [SIZE_WIDTH-1:0] pick_size_o
);

  logic [SIZE_WIDTH-1:0] size_q;
  scan_tok_t             tok_q;
  logic [IDX_W-1:0]      pick_idx_q;
  logic [SIZE_WIDTH-1:0] pick_size_q;
  logic                  eligible;
  logic                  better;
  logic                  take;

  always_comb begin
    eligible = tok_i.active && in_range_i && (size_q >= data_i);
    better   = ((policy_i == FIT_BEST) && (size_q < pick_size_i)) ||
               ((policy_i == FIT_WORST) && (size_q > pick_size_i));
    take     = eligible && (!tok_i.found || better);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q.active <= tok_i.active;
      tok_q.found  <= tok_i.found | eligible;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_idx_q  <= take ? IDX_W'(INDEX) : pick_idx_i;
    pick_size_q <= take ? size_q : pick_size_i;
    if (wr_cmd_i.en && (wr_sel_i == IDX_W'(INDEX))) begin
      size_q <= wr_cmd_i.sub ? (size_q - data_i) : data_i;
    end
  end

  assign tok_o       = tok_q;
  assign pick_idx_o  = pick_idx_q;
  assign pick_size_o = pick_size_q;

endmodule

// ----- sv/fpba_checker.sv -----
// port level checks of the fit policy block allocator
module fpba_checker
  import fpba_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid,
  input logic               req_ready,
  input logic               req_action,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic               rsp_granted,
  input logic [INDEX_W-1:0] rsp_chosen
);

  // a stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !rsp_ready) |=> ($stable(rsp_granted) && $stable(rsp_chosen)))
    else $error("result payload changed while stalled");

  // a refused request reports block zero
  a_refuse_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !rsp_granted) |-> (rsp_chosen == '0))
    else $error("refused request reports a nonzero block");

  // an accepted allocation blocks further requests while it searches
  a_busy_after_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid && req_ready && (req_action == ACT_REQUEST)) |=> !req_ready)
    else $error("request taken during a search");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid   (req_i.valid),
  .req_ready   (req_i.ready),
  .req_action  (req_i.action),
  .rsp_valid   (rsp_o.valid),
  .rsp_ready   (rsp_o.ready),
  .rsp_granted (rsp_o.granted),
  .rsp_chosen  (rsp_o.chosen_block)
);
